>>> hdl/bdad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdad_pkg
// Shared types, constants and helpers for the binary to decimal ASCII
// digit converter.
// ----------------------------------------------------------------------------
package bdad_pkg;

  localparam int MaxDigits = 5;
  localparam int IdxW      = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  localparam int ValueW    = 16;
  localparam int CountW    = 3;
  localparam int RowW      = 3;
  localparam int ColW      = 6;
  localparam int CharW     = 6;
  localparam int DigitW    = 4;

  // floor(n / 10) == (n * RecipTen) >> RecipShift for n <= 43698
  localparam logic [ValueW-1:0] RecipTen   = 16'd52429;
  localparam int                RecipShift = 19;

  localparam logic [CharW-1:0] CharZero = 6'h30;

  typedef enum logic [1:0] {
    StIdle,
    StConvert,
    StEmit
  } bdad_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic advance;
  } bdad_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic emit_last;
  } bdad_stat_t;

  // index of the most significant digit to emit, from the clamped count
  function automatic logic [IdxW-1:0] last_index(input logic [CountW-1:0] count);
    logic [IdxW-1:0] res;
    if (count == '0) begin
      res = '0;
    end else if (int'(count) > MaxDigits) begin
      res = IdxW'(MaxDigits - 1);
    end else begin
      res = IdxW'(count - CountW'(1));
    end
    return res;
  endfunction

endpackage

>>> hdl/bdad_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdad_ctrl
// Sequencer: accept an item, run one divide step per digit, then emit
// the characters one transfer at a time.
// ----------------------------------------------------------------------------
module bdad_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bdad_pkg::bdad_stat_t stat_i,
  output bdad_pkg::bdad_cmd_t  cmd_o
);
  import bdad_pkg::*;

  bdad_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StConvert;
      end
      StConvert: begin
        if (stat_i.conv_last) state_d = StEmit;
      end
      StEmit: begin
        if (out_ready_i && stat_i.emit_last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StConvert: begin
        cmd_o.step = 1'b1;
      end
      StEmit: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/bdad_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdad_dpath
// Datapath: magnitude, shared divide-by-ten step, digit registers and
// character formatting.
// ----------------------------------------------------------------------------
module bdad_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bdad_pkg::ValueW-1:0]   value_i,
  input  logic [bdad_pkg::CountW-1:0]   digit_count_i,
  input  logic [bdad_pkg::RowW-1:0]     row_i,
  input  logic [bdad_pkg::ColW-1:0]     column_i,
  input  bdad_pkg::bdad_cmd_t           cmd_i,
  output bdad_pkg::bdad_stat_t          stat_o,
  output logic [bdad_pkg::CharW-1:0]    char_code_o,
  output logic [bdad_pkg::RowW-1:0]     row_out_o,
  output logic [bdad_pkg::ColW-1:0]     column_out_o,
  output logic                          positioned_o,
  output logic                          last_char_o
);
  import bdad_pkg::*;

  logic [ValueW-1:0]   val_q, val_d;
  logic [IdxW-1:0]     last_q;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [RowW-1:0]     row_q;
  logic [ColW-1:0]     col_q;
  logic [DigitW-1:0]   digit_q [MaxDigits];

  logic [ValueW-1:0]   mag;
  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   quot;
  logic [ValueW-1:0]   quot_x10;
  logic [ValueW-1:0]   rem_full;
  logic                first;

  assign mag      = value_i[ValueW-1] ? (~value_i + ValueW'(1)) : value_i;
  assign prod     = (2*ValueW)'(val_q) * (2*ValueW)'(RecipTen);
  assign quot     = ValueW'(prod >> RecipShift);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = val_q - quot_x10;

  always_comb begin
    val_d = val_q;
    idx_d = idx_q;
    if (cmd_i.load) begin
      val_d = mag;
      idx_d = '0;
    end else if (cmd_i.step) begin
      val_d = quot;
      if (idx_q != last_q) idx_d = idx_q + IdxW'(1);
    end else if (cmd_i.advance) begin
      if (idx_q != '0) idx_d = idx_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      idx_q  <= '0;
      last_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      val_q <= val_d;
      idx_q <= idx_d;
      if (cmd_i.load) begin
        last_q <= last_index(digit_count_i);
        row_q  <= row_i;
        col_q  <= column_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      digit_q[idx_q] <= rem_full[DigitW-1:0];
    end
  end

  assign stat_o.conv_last = (idx_q == last_q);
  assign stat_o.emit_last = (idx_q == '0);

  assign first        = (idx_q == last_q);
  assign char_code_o  = CharZero | CharW'(digit_q[idx_q]);
  assign row_out_o    = first ? row_q : '0;
  assign column_out_o = first ? col_q : '0;
  assign positioned_o = first;
  assign last_char_o  = (idx_q == '0);

endmodule

>>> hdl/binary_to_decimal_ascii_digits.sv
`timescale 1ns / 1ps
// Throughput: one character per cycle while out_ready_i is high.
// The shared divide-by-ten step produces one digit per cycle; one item is in work at a time.
// Reset: rst_ni asynchronous active low returns the sequencer to idle, ready for input,
// and clears the working value, index and position registers.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_digits
// Converts a signed value to its lowest decimal digits as ASCII characters,
// most significant first, one character per output transfer.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_digits (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bdad_pkg::ValueW-1:0] value_i,
  input  logic [bdad_pkg::CountW-1:0] digit_count_i,
  input  logic [bdad_pkg::RowW-1:0]   row_i,
  input  logic [bdad_pkg::ColW-1:0]   column_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bdad_pkg::CharW-1:0]  char_code_o,
  output logic [bdad_pkg::RowW-1:0]   row_out_o,
  output logic [bdad_pkg::ColW-1:0]   column_out_o,
  output logic                        positioned_o,
  output logic                        last_char_o
);
  import bdad_pkg::*;

  bdad_cmd_t  cmd;
  bdad_stat_t stat;

  bdad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bdad_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .row_i         (row_i),
    .column_i      (column_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .char_code_o   (char_code_o),
    .row_out_o     (row_out_o),
    .column_out_o  (column_out_o),
    .positioned_o  (positioned_o),
    .last_char_o   (last_char_o)
  );

endmodule

>>> hdl/bdad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdad_checker
// Port-level checks of the digit converter, bound to the top level.
// ----------------------------------------------------------------------------
module bdad_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [bdad_pkg::CharW-1:0]  char_code_o,
  input logic [bdad_pkg::RowW-1:0]   row_out_o,
  input logic [bdad_pkg::ColW-1:0]   column_out_o,
  input logic                        positioned_o,
  input logic                        last_char_o
);
  import bdad_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_code_o)
      && $stable(positioned_o) && $stable(last_char_o))
    else $error("output held item changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while characters still pending");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_char_o |=> !out_valid_o && in_ready_o)
    else $error("no return to idle after final character");

  a_in_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input ready too soon after transfer");

  a_pos_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !positioned_o |-> row_out_o == '0 && column_out_o == '0
      && char_code_o[CharW-1:CharW-2] == 2'b11)
    else $error("unpositioned character carries position or bad code");

endmodule

bind binary_to_decimal_ascii_digits bdad_checker u_bdad_checker (.*);
